// ===== rtl/core/fxmc_pkg.sv =====
// Shared constants and types for the folded XOR multiplicative checksum.
// No dependencies; all files of the block but the interfaces import it.

package fxmc_pkg;

   // Mixing constant and its 32-bit halves for the split multiplication.
   localparam logic [63:0] MIX_MULTIPLIER = 64'd5700357406446321664;
   localparam logic [31:0] MIX_MULT_LO    = MIX_MULTIPLIER[31:0];
   localparam logic [31:0] MIX_MULT_HI    = MIX_MULTIPLIER[63:32];

   localparam logic [7:0] UPPER_FIRST      = 8'd65;
   localparam logic [7:0] UPPER_LAST       = 8'd90;
   localparam logic [7:0] CASE_OFFSET      = 8'd32;
   localparam logic [2:0] LANE_LAST        = 3'd6;
   localparam logic [7:0] SHIFT_BASE       = 8'd64;
   localparam logic [7:0] SHIFT_LIMIT      = 8'h40;
   localparam logic [7:0] HASH_WIDTH_RESET = 8'd16;

   // Finished message handed from the accumulator to the finishing pipeline.
   typedef struct packed {
      logic        valid;
      logic [63:0] accumulator;
   } fxmc_fin_req_type;

endpackage

// ===== rtl/core/fxmc_if.sv =====
// Channel interfaces of the checksum block: byte requests and checksum responses.
// Standalone; carries valid, ready and the payload of each channel.

interface fxmc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fxmc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] checksum;

   modport source (output valid, output checksum, input ready);
   modport sink   (input valid, input checksum, output ready);
endinterface

// ===== rtl/core/fxmc_finish.sv =====
// Finishing pipeline: split 64-bit multiply, width shift and the response register.
// Depends on fxmc_pkg and fxmc_rsp_if.

module fxmc_finish
   import fxmc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  fxmc_fin_req_type fin_req,
   input  logic [7:0]       hash_width,
   output logic             advance,
   fxmc_rsp_if.source       rsp_chan
);

   logic        s1_valid_ff;
   logic [63:0] s1_acc_ff;
   logic        s2_valid_ff;
   logic [63:0] pp_lo_ff;
   logic [31:0] pp_cross_a_ff;
   logic [31:0] pp_cross_b_ff;
   logic        rsp_valid_ff;
   logic [15:0] checksum_ff;

   logic [63:0] pp_lo_in;
   logic [31:0] pp_cross_a_in;
   logic [31:0] pp_cross_b_in;
   logic [31:0] cross_sum;
   logic [63:0] product;
   logic [7:0]  shift_amount;
   logic [63:0] shifted;
   logic [15:0] checksum_in;

   // The whole pipeline moves together whenever the response slot frees up.
   assign advance = !rsp_valid_ff || rsp_chan.ready;

   // Only the low 64 bits of the product matter, so the high-by-high term drops
   // and the cross terms need just their low 32 bits.
   always_comb begin
      pp_lo_in      = 64'(s1_acc_ff[31:0]) * 64'(MIX_MULT_LO);
      pp_cross_a_in = s1_acc_ff[63:32] * MIX_MULT_LO;
      pp_cross_b_in = s1_acc_ff[31:0] * MIX_MULT_HI;
   end

   always_comb begin
      cross_sum    = pp_cross_a_ff + pp_cross_b_ff;
      product      = pp_lo_ff + {cross_sum, 32'd0};
      shift_amount = SHIFT_BASE - hash_width;
      shifted      = product >> shift_amount[5:0];
      if (shift_amount >= SHIFT_LIMIT) begin
         checksum_in = 16'd0;
      end else begin
         checksum_in = shifted[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= fin_req.valid;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_acc_ff     <= fin_req.accumulator;
         pp_lo_ff      <= pp_lo_in;
         pp_cross_a_ff <= pp_cross_a_in;
         pp_cross_b_ff <= pp_cross_b_in;
         checksum_ff   <= checksum_in;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.checksum = checksum_ff;

endmodule

// ===== rtl/core/folded_xor_multiplicative_checksum.sv =====
// Folded XOR multiplicative checksum: throughput is one message byte per cycle while
// not stalled; a 16-bit checksum follows the beat carrying the last byte through the
// stage-one, partial-product and response registers; the lane XOR is done as the
// beat is taken. The split multiply and shift run in a three-register finishing
// pipeline that stalls only while a response waits to be taken.
// Synchronous active-high reset clears the accumulator, lane and pipeline, width to 16.

module folded_xor_multiplicative_checksum
   import fxmc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_en,
   input  logic [7:0] csr_write_data,
   fxmc_req_if.sink   req_chan,
   fxmc_rsp_if.source rsp_chan
);

   logic [7:0]  hash_width_ff;
   logic [63:0] acc_ff;
   logic [2:0]  lane_ff;
   logic [63:0] acc_in;
   logic [2:0]  lane_in;

   logic             advance;
   logic             accept;
   logic [7:0]       folded_byte;
   logic [63:0]      extended;
   logic [63:0]      acc_mixed;
   fxmc_fin_req_type fin_req;

   assign req_chan.ready = advance;
   assign accept         = req_chan.valid && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_width_ff <= HASH_WIDTH_RESET;
      end else if (csr_write_en) begin
         hash_width_ff <= csr_write_data;
      end
   end

   always_comb begin
      if (req_chan.data_byte >= UPPER_FIRST && req_chan.data_byte <= UPPER_LAST) begin
         folded_byte = req_chan.data_byte + CASE_OFFSET;
      end else begin
         folded_byte = req_chan.data_byte;
      end
      extended  = {{56{folded_byte[7]}}, folded_byte};
      acc_mixed = acc_ff ^ (extended << {lane_ff, 3'b000});
   end

   // Zero bytes leave both the accumulator and the lane untouched.
   always_comb begin
      acc_in  = acc_ff;
      lane_in = lane_ff;
      if (req_chan.data_byte != 8'd0) begin
         acc_in = acc_mixed;
         if (lane_ff < LANE_LAST) begin
            lane_in = lane_ff + 3'd1;
         end else begin
            lane_in = 3'd0;
         end
      end
      fin_req.valid       = accept && req_chan.last_byte;
      fin_req.accumulator = acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= 64'd0;
         lane_ff <= 3'd0;
      end else if (accept) begin
         if (req_chan.last_byte) begin
            acc_ff  <= 64'd0;
            lane_ff <= 3'd0;
         end else begin
            acc_ff  <= acc_in;
            lane_ff <= lane_in;
         end
      end
   end

   fxmc_finish u_finish (
      .clock      (clock),
      .reset      (reset),
      .fin_req    (fin_req),
      .hash_width (hash_width_ff),
      .advance    (advance),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== rtl/core/fxmc_checker.sv =====
// Port-level checks for the folded XOR multiplicative checksum.
// Depends on fxmc_pkg; bound to the top level at the end of this file.

module fxmc_checker
   import fxmc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        csr_write_en,
   input logic [7:0]  csr_write_data,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_checksum
);

   logic [7:0] width_ff;

   // Shadow copy of the width register as seen on the port.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= HASH_WIDTH_RESET;
      end else if (csr_write_en) begin
         width_ff <= csr_write_data;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_checksum))
      else $error("checksum changed while stalled");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with an empty response slot");

   a_wide_shift_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (width_ff == 8'd0 || width_ff > SHIFT_BASE) |-> rsp_checksum == 16'd0)
      else $error("nonzero checksum for an out-of-range width");

endmodule

bind folded_xor_multiplicative_checksum fxmc_checker u_fxmc_checker (
   .clock          (clock),
   .reset          (reset),
   .csr_write_en   (csr_write_en),
   .csr_write_data (csr_write_data),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_checksum   (rsp_chan.checksum)
);

// ===== tb/folded_xor_multiplicative_checksum_tb.sv =====
// Self-checking testbench for the folded XOR multiplicative checksum block.
// Depends on fxmc_pkg and on the fxmc_req_if and fxmc_rsp_if channel interfaces.

// Tracks the running fold and the width setting, and queues the checksums owed.
class checksum_scoreboard;
   logic [63:0] fold_acc;
   logic [2:0]  lane;
   logic [7:0]  width;
   logic [15:0] sums_due[$];
   int          errors;
   int          bytes_taken;
   int          sums_taken;

   function new();
      fold_acc    = '0;
      lane        = '0;
      width       = fxmc_pkg::HASH_WIDTH_RESET;
      errors      = 0;
      bytes_taken = 0;
      sums_taken  = 0;
   endfunction

   function void set_width(logic [7:0] w);
      width = w;
   endfunction

   function void note_byte(logic [7:0] b, logic last);
      logic [7:0]  folded;
      logic [63:0] widened;
      logic [7:0]  shift;
      logic [63:0] product;
      logic [63:0] shifted;
      bytes_taken++;
      if (b != 8'd0) begin
         folded = b;
         if (folded >= fxmc_pkg::UPPER_FIRST && folded <= fxmc_pkg::UPPER_LAST) begin
            folded = folded + fxmc_pkg::CASE_OFFSET;
         end
         widened  = {{56{folded[7]}}, folded};
         fold_acc = fold_acc ^ (widened << (8 * lane));
         lane     = (lane < fxmc_pkg::LANE_LAST) ? lane + 3'd1 : 3'd0;
      end
      if (last) begin
         // The shift wraps modulo 256, so widths above 64 also land out of range.
         shift   = fxmc_pkg::SHIFT_BASE - width;
         product = fold_acc * fxmc_pkg::MIX_MULTIPLIER;
         shifted = (shift >= fxmc_pkg::SHIFT_LIMIT) ? 64'd0 : product >> shift;
         sums_due.push_back(shifted[15:0]);
         fold_acc = '0;
         lane     = '0;
      end
   endfunction

   function void check_sum(logic [15:0] got);
      logic [15:0] want;
      sums_taken++;
      if (sums_due.size() == 0) begin
         $error("checksum: beat with nothing expected, expected none, actual %h", got);
         errors++;
      end else begin
         want = sums_due.pop_front();
         if (got !== want) begin
            $error("checksum mismatch: expected %h, actual %h", want, got);
            errors++;
         end
      end
   endfunction
endclass

module folded_xor_multiplicative_checksum_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fxmc_pkg::*;

   localparam int STALL_LIMIT = 2000;

   logic       clock;
   logic       reset;
   logic       csr_write_en;
   logic [7:0] csr_write_data;
   bit         busy;
   int         idle_cycles;
   int         widths_used;

   fxmc_req_if req_if();
   fxmc_rsp_if rsp_if();

   checksum_scoreboard ledger = new();

   folded_xor_multiplicative_checksum u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_chan       (req_if),
      .rsp_chan       (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Inputs only change just after a rising edge, so the levels seen at the falling
   // edge are exactly the ones that the next rising edge acts on.
   always @(negedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_if.valid && rsp_if.ready) begin
            ledger.check_sum(rsp_if.checksum);
         end
         if (req_if.valid && req_if.ready) begin
            ledger.note_byte(req_if.data_byte, req_if.last_byte);
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Result side: in busy stretches it holds ready low until a beat shows up and
   // then for a random number of further cycles.
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (busy) begin
            stall = $urandom_range(0, 11);
            rsp_if.ready <= 1'b0;
            do @(negedge clock); while (!rsp_if.valid);
            @(posedge clock);
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(negedge clock); while (!rsp_if.valid);
         @(posedge clock);
      end
   end

   // Called just after a rising edge; returns just after the edge that took the beat.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = busy ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      req_if.last_byte <= last;
      do @(negedge clock); while (!req_if.ready);
      @(posedge clock);
   endtask

   // Drops valid and lets the finishing pipeline drain before any register write.
   task automatic settle();
      req_if.valid <= 1'b0;
      while (ledger.sums_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_width(input logic [7:0] w);
      csr_write_en   <= 1'b1;
      csr_write_data <= w;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      ledger.set_width(w);
      widths_used++;
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1, 2:    return 8'($urandom_range(65, 90));
         3:       return 8'($urandom_range(128, 255));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) begin
         send_byte(pick_byte(), i == len - 1);
      end
   endtask

   initial begin
      logic [7:0] phase_width[10];
      logic [7:0] upper_run[8];
      logic [7:0] mixed_run[7];
      int         sent;
      int         len;

      phase_width = '{8'd16, 8'd0, 8'd1, 8'd64, 8'd65, 8'd255, 8'd63, 8'd32, 8'd8, 8'd0};
      phase_width[9] = 8'($urandom_range(0, 255));
      upper_run = '{8'h41, 8'h5A, 8'h40, 8'h5B, 8'h61, 8'h80, 8'h7F, 8'hFF};
      mixed_run = '{8'h55, 8'hAA, 8'h33, 8'hCC, 8'h0F, 8'hF0, 8'h12};

      idle_cycles = 0;
      widths_used = 0;
      busy        = 1'b0;
      reset            <= 1'b1;
      csr_write_en     <= 1'b0;
      csr_write_data   <= '0;
      req_if.valid     <= 1'b0;
      req_if.data_byte <= '0;
      req_if.last_byte <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset width: case-fold borders, sign extension, a lane
      // wrap past position 6, a lone zero byte marked last and zeros mid-message.
      foreach (upper_run[i]) send_byte(upper_run[i], i == 7);
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFE, 1'b1);
      busy = 1'b1;
      foreach (mixed_run[i]) send_byte(mixed_run[i], i == 6);
      send_byte(8'h7A, 1'b1);
      settle();

      for (int p = 0; p < 10; p++) begin
         if (p > 0) begin
            write_width(phase_width[p]);
         end
         busy = (p % 3 != 2);
         sent = 0;
         while (sent < 100) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40)
                                                 : $urandom_range(1, 16);
            send_message(len);
            sent += len;
         end
         settle();
      end

      $display("Covered %0d byte beats and %0d checksums over %0d width settings,",
               ledger.bytes_taken, ledger.sums_taken, widths_used + 1);
      $display("with random gaps and back-pressure on both channels in most phases.");
      if (ledger.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
